// ===== design/spmq_pkg.sv =====
// spmq_pkg: shared types and constants for the spatial mean requantization core.
// Used by the queue, front, back and top modules and the testbench; depends on nothing.
package spmq_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int CHAN_IDX_W  = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MEAN_MULT   = 3'd0,
      REG_MEAN_SHIFT  = 3'd1,
      REG_ZERO_MULT   = 3'd2,
      REG_ZERO_SHIFT  = 3'd3,
      REG_IN_ZP       = 3'd4,
      REG_OUT_ZP      = 3'd5,
      REG_CHAN_COUNT  = 3'd6,
      REG_PIX_COUNT   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [30:0]        sum_mult;
      logic signed [5:0]  sum_shift;
      logic [30:0]        zero_multiplier;
      logic signed [5:0]  zero_shift;
      logic [7:0]         input_zero_point;
      logic [7:0]         output_zero_point;
      logic [8:0]         channel_count;
      logic [15:0]        pixel_count;
   } cfg_type;

   typedef struct packed {
      logic                  last_channel;
      logic [CHAN_IDX_W-1:0] channel_index;
   } tag_type;

   localparam int TAG_W = $bits(tag_type);

endpackage

// ===== design/spmq_ram.sv =====
// spmq_ram: generic single-write, single-read RAM with registered read data.
// Read returns the old word when read and write hit the same address. No dependencies.
module spmq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/spmq_queue.sv =====
// spmq_queue: short fifo of finished channel sums between front and back.
// Depends on spmq_pkg for its depth.
module spmq_queue #(
   parameter int WIDTH = 33
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic                          pop_valid,
   output logic [WIDTH-1:0]              pop_data,
   output logic [spmq_pkg::QCOUNT_W-1:0] count
);
   import spmq_pkg::*;

   logic [WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCOUNT_W'(push) - QCOUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== design/spmq_front.sv =====
// spmq_front: sample intake, channel/pixel position tracking and the per-channel
// accumulator read-modify-write. Depends on spmq_pkg and spmq_ram.
module spmq_front #(
   parameter int MAX_CHANNELS = 256,
   parameter int SUM_WIDTH    = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  spmq_pkg::cfg_type               cfg,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [spmq_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic [spmq_pkg::QCOUNT_W-1:0]   q_count,
   output logic                            q_push,
   output logic [SUM_WIDTH-1:0]            q_sum,
   output spmq_pkg::tag_type               q_tag
);
   import spmq_pkg::*;

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CC_W = (CH_W + 1 > 9) ? CH_W + 1 : 9;

   logic [CH_W-1:0]         chan_ff, chan_in;
   logic [15:0]             pix_ff, pix_in;
   logic [MAX_CHANNELS-1:0] valid_ff, valid_in;

   logic                    s1_valid_ff;
   logic [CH_W-1:0]         s1_addr_ff;
   logic [SAMPLE_W-1:0]     s1_sample_ff;
   logic                    s1_first_ff;
   logic                    s1_lastpix_ff;
   logic                    s1_lastch_ff;
   logic                    s1_vbit_ff;
   logic                    s1_fwd_ff;
   logic [SUM_WIDTH-1:0]    wr_data_ff;

   logic [CC_W-1:0]         cc_raw, cc_eff;
   logic [15:0]             pc_eff;
   logic                    last_chan, last_pix, accept;
   logic [SUM_WIDTH-1:0]    ram_rdata, base, s1_sum;
   logic [QCOUNT_W:0]       room_need;

   // effective counts: zero acts as one, channel count saturates at the store depth
   always_comb begin
      cc_raw = CC_W'(cfg.channel_count);
      if (cc_raw == '0) begin
         cc_eff = CC_W'(1);
      end else if (cc_raw > CC_W'(MAX_CHANNELS)) begin
         cc_eff = CC_W'(MAX_CHANNELS);
      end else begin
         cc_eff = cc_raw;
      end
      pc_eff    = (cfg.pixel_count == '0) ? 16'd1 : cfg.pixel_count;
      last_chan = (CC_W'(chan_ff) + CC_W'(1)) >= cc_eff;
      last_pix  = pix_ff >= (pc_eff - 16'd1);
   end

   // keep room in the queue for the word in flight plus the one taken now
   assign q_push    = s1_valid_ff & s1_lastpix_ff;
   assign room_need = {1'b0, q_count} + (QCOUNT_W + 1)'(q_push);
   assign req_ready = room_need < (QCOUNT_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid & req_ready;

   always_comb begin
      chan_in = chan_ff;
      pix_in  = pix_ff;
      if (accept) begin
         if (last_chan) begin
            chan_in = '0;
            pix_in  = last_pix ? 16'd0 : pix_ff + 16'd1;
         end else begin
            chan_in = chan_ff + CH_W'(1);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (s1_valid_ff) begin
         valid_in[s1_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff     <= '0;
         pix_ff      <= '0;
         valid_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         chan_ff     <= chan_in;
         pix_ff      <= pix_in;
         valid_ff    <= valid_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff    <= chan_ff;
         s1_sample_ff  <= req_sample;
         s1_first_ff   <= (pix_ff == '0);
         s1_lastpix_ff <= last_pix;
         s1_lastch_ff  <= last_chan;
         s1_vbit_ff    <= valid_ff[chan_ff];
         // ram read misses the write landing on the same edge
         s1_fwd_ff     <= s1_valid_ff && (s1_addr_ff == chan_ff);
      end
      if (s1_valid_ff) begin
         wr_data_ff <= s1_sum;
      end
   end

   spmq_ram #(
      .WIDTH (SUM_WIDTH),
      .DEPTH (MAX_CHANNELS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_sum),
      .rd_en   (accept),
      .rd_addr (chan_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (s1_fwd_ff) begin
         base = wr_data_ff;
      end else if (s1_vbit_ff) begin
         base = ram_rdata;
      end else begin
         base = '0;
      end
      s1_sum = s1_first_ff ? SUM_WIDTH'(s1_sample_ff) : base + SUM_WIDTH'(s1_sample_ff);
   end

   assign q_sum               = s1_sum;
   assign q_tag.channel_index = CHAN_IDX_W'(s1_addr_ff);
   assign q_tag.last_channel  = s1_lastch_ff;

endmodule

// ===== design/spmq_requant.sv =====
// spmq_requant: four-stage fixed-point requantizer (left shift, rounding doubling
// high multiply, rounding right shift). Depends on nothing.
module spmq_requant #(
   parameter int TAG_W = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                valid_in,
   input  logic [31:0]         x_in,
   input  logic [30:0]         mult_in,
   input  logic signed [5:0]   shift_in,
   input  logic [TAG_W-1:0]    tag_in,
   output logic                valid_out,
   output logic signed [32:0]  y_out,
   output logic [TAG_W-1:0]    tag_out
);

   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic [TAG_W-1:0]    tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [31:0]         xs_ff;
   logic [30:0]         mult_ff;
   logic [4:0]          rs1_ff, rs2_ff, rs3_ff;
   logic signed [63:0]  prod_ff;
   logic signed [32:0]  hi_ff, y_ff;

   logic [4:0]          ls;
   logic [5:0]          neg;
   logic [4:0]          rs;
   logic signed [63:0]  ab, ab_floor;
   logic signed [32:0]  hi_trunc, q;
   logic [32:0]         mask, rem, thr;

   // shift code -32 means a right shift by 31
   always_comb begin
      ls  = (!shift_in[5] && shift_in != '0) ? shift_in[4:0] : 5'd0;
      neg = 6'(-shift_in);
      rs  = !shift_in[5] ? 5'd0 : (neg[5] ? 5'd31 : neg[4:0]);
   end

   // truncate toward zero after the nudge
   always_comb begin
      ab       = prod_ff + ((prod_ff >= 0) ? 64'sd1073741824 : -64'sd1073741823);
      ab_floor = ab >>> 31;
      hi_trunc = 33'(ab_floor) + 33'((ab < 0) && (ab[30:0] != '0));
   end

   // round to nearest, ties away from zero
   always_comb begin
      mask = (33'd1 << rs3_ff) - 33'd1;
      rem  = hi_ff & mask;
      q    = hi_ff >>> rs3_ff;
      thr  = (mask >> 1) + 33'(hi_ff < 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         xs_ff   <= x_in << ls;
         mult_ff <= mult_in;
         rs1_ff  <= rs;
         tag1_ff <= tag_in;
         prod_ff <= $signed(xs_ff) * $signed({1'b0, mult_ff});
         rs2_ff  <= rs1_ff;
         tag2_ff <= tag1_ff;
         hi_ff   <= hi_trunc;
         rs3_ff  <= rs2_ff;
         tag3_ff <= tag2_ff;
         y_ff    <= q + 33'(rem > thr);
         tag4_ff <= tag3_ff;
      end
   end

   assign valid_out = v4_ff;
   assign y_out     = y_ff;
   assign tag_out   = tag4_ff;

endmodule

// ===== design/spmq_back.sv =====
// spmq_back: requantizes finished channel sums, adds the zero point offset,
// clamps to 0..255 and holds the result word. Depends on spmq_pkg and spmq_requant.
module spmq_back #(
   parameter int SUM_WIDTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spmq_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  logic [SUM_WIDTH-1:0] q_sum,
   input  spmq_pkg::tag_type    q_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_mean,
   output spmq_pkg::tag_type    rsp_tag
);
   import spmq_pkg::*;

   logic                rsp_valid_ff;
   logic [7:0]          rsp_mean_ff;
   tag_type             rsp_tag_ff;
   logic signed [33:0]  bias_ff;

   logic                adv;
   logic                mq_valid;
   logic signed [32:0]  mq_y, bias_y;
   logic [TAG_W-1:0]    mq_tag;
   logic signed [34:0]  acc;
   logic [7:0]          clamped;

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = q_valid && adv;

   spmq_requant #(
      .TAG_W (TAG_W)
   ) u_mean_rq (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .valid_in  (q_pop),
      .x_in      (32'(q_sum)),
      .mult_in   (cfg.sum_mult),
      .shift_in  (cfg.sum_shift),
      .tag_in    (q_tag),
      .valid_out (mq_valid),
      .y_out     (mq_y),
      .tag_out   (mq_tag)
   );

   // offset path runs freely off the configuration
   spmq_requant #(
      .TAG_W (1)
   ) u_bias_rq (
      .clock     (clock),
      .reset     (reset),
      .enable    (1'b1),
      .valid_in  (1'b1),
      .x_in      (32'(cfg.input_zero_point)),
      .mult_in   (cfg.zero_multiplier),
      .shift_in  (cfg.zero_shift),
      .tag_in    (1'b0),
      .valid_out (),
      .y_out     (bias_y),
      .tag_out   ()
   );

   always_ff @(posedge clock) begin
      bias_ff <= $signed({26'd0, cfg.output_zero_point}) - 34'(bias_y);
   end

   always_comb begin
      acc = 35'(mq_y) + 35'(bias_ff);
      if (acc < 0) begin
         clamped = 8'd0;
      end else if (acc > 35'sd255) begin
         clamped = 8'd255;
      end else begin
         clamped = acc[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_mean_ff <= clamped;
         rsp_tag_ff  <= tag_type'(mq_tag);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mean  = rsp_mean_ff;
   assign rsp_tag   = rsp_tag_ff;

endmodule

// ===== design/spatial_mean_uint8_requant_core.sv =====
// Takes one uint8 sample per clock, channel fastest then pixel, and keeps a running
// sum per channel in a RAM of MAX_CHANNELS words; a one-word bypass lets the same
// channel be updated on consecutive clocks, so the sustained rate is one sample per
// cycle, set by the single read-modify-write of the sum RAM. On a channel's last-pixel
// sample its sum enters a four-deep queue and a requantizer pipeline whose result is
// registered as the mean word. Input stalls only while the queue is nearly full.
// Configuration registers are to be written while the block is idle; the block does
// not enforce this. After a write the registered offset path needs to settle.
module spatial_mean_uint8_requant_core #(
   parameter int MAX_CHANNELS = 256,
   parameter int SUM_WIDTH    = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] sample
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,   // [7:0] mean_value, [15:8] channel_index
   output logic                               rsp_tlast,   // last_channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spmq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spmq_pkg::CSR_DATA_W-1:0]    csr_data
);
   import spmq_pkg::*;

   cfg_type              cfg_ff, cfg_in;

   logic                 q_push, q_pop, q_valid;
   logic [SUM_WIDTH-1:0] q_push_sum, q_pop_sum;
   tag_type              q_push_tag, q_pop_tag;
   logic [QCOUNT_W-1:0]  q_count;
   tag_type              rsp_tag;
   logic [7:0]           rsp_mean;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_MEAN_MULT:  cfg_in.sum_mult          = csr_data[30:0];
            REG_MEAN_SHIFT: cfg_in.sum_shift         = $signed(csr_data[5:0]);
            REG_ZERO_MULT:  cfg_in.zero_multiplier   = csr_data[30:0];
            REG_ZERO_SHIFT: cfg_in.zero_shift        = $signed(csr_data[5:0]);
            REG_IN_ZP:      cfg_in.input_zero_point  = csr_data[7:0];
            REG_OUT_ZP:     cfg_in.output_zero_point = csr_data[7:0];
            REG_CHAN_COUNT: cfg_in.channel_count     = csr_data[8:0];
            REG_PIX_COUNT:  cfg_in.pixel_count       = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sum_mult          <= 31'd1073741824;
         cfg_ff.sum_shift         <= '0;
         cfg_ff.zero_multiplier   <= 31'd1073741824;
         cfg_ff.zero_shift        <= '0;
         cfg_ff.input_zero_point  <= '0;
         cfg_ff.output_zero_point <= '0;
         cfg_ff.channel_count     <= 9'd1;
         cfg_ff.pixel_count       <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spmq_front #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SUM_WIDTH    (SUM_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_sample (req_tdata),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_sum      (q_push_sum),
      .q_tag      (q_push_tag)
   );

   spmq_queue #(
      .WIDTH (SUM_WIDTH + TAG_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({q_push_tag, q_push_sum}),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  ({q_pop_tag, q_pop_sum}),
      .count     (q_count)
   );

   spmq_back #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_sum     (q_pop_sum),
      .q_tag     (q_pop_tag),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_mean  (rsp_mean),
      .rsp_tag   (rsp_tag)
   );

   assign rsp_tdata = {rsp_tag.channel_index, rsp_mean};
   assign rsp_tlast = rsp_tag.last_channel;

   // a finished sum always finds a free queue slot
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < QCOUNT_W'(QUEUE_DEPTH)))
      else $error("sum queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      (q_count == QCOUNT_W'(QUEUE_DEPTH)) |-> !req_tready)
      else $error("input taken with full sum queue");

   // input back-pressure comes only from a nearly full queue
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (q_count >= QCOUNT_W'(QUEUE_DEPTH - 1)))
      else $error("input stalled with queue room");

endmodule

// ===== verif/testbench.sv =====
// testbench for spatial_mean_uint8_requant_core: streams uint8 image samples and checks
// every channel mean word against a cycle-free predictor kept inside this module.
// Depends on spmq_pkg for the register index names and the register layout.
module testbench;
   import spmq_pkg::*;

   localparam int CHANNELS = 256;
   localparam int SUM_W    = 24;
   localparam int SETTLE   = 12;

   typedef struct packed {
      logic [7:0] mean_value;
      logic [7:0] channel_index;
      logic       last_channel;
   } mean_word;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;   // [7:0] sample
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;        // [7:0] mean_value, [15:8] channel_index
   logic                   rsp_tlast;        // last_channel
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_MEAN_MULT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // predictor state
   cfg_type          cfg;
   logic [SUM_W-1:0] sums [CHANNELS];
   int               chan_pos;
   logic [15:0]      pix_pos;
   mean_word         pending_means [$];

   bit no_idle = 1'b0;
   int hold_left = 0;
   int sample_count = 0;
   int write_count = 0;
   int setting_count = 0;
   int means_seen = 0;
   int input_stall_cycles = 0;
   int error_count = 0;

   spatial_mean_uint8_requant_core #(
      .MAX_CHANNELS (CHANNELS),
      .SUM_WIDTH    (SUM_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("spatial_mean_uint8_requant_core: mismatch");
      $finish;
   end

   // left shift, q31 multiply with rounding high half, then rounding right shift
   function automatic longint scale_q31(input longint x, input logic [30:0] mult,
                                        input logic [5:0] shift);
      int          sh, ls, rs;
      logic [31:0] xs;
      longint      v, m, ab, hi, rem, q, mask, thr;
      sh = $signed(shift);
      ls = (sh > 0) ? sh : 0;
      rs = (sh > 0) ? 0 : -sh;
      if (rs > 31) rs = 31;
      xs = x[31:0];
      xs = xs << ls;
      v = $signed(xs);
      m = mult;
      ab = v * m;
      if (ab >= 0) ab = ab + 64'sd1073741824;
      else ab = ab + 64'sd1 - 64'sd1073741824;
      hi = ab / 64'sd2147483648;
      mask = (64'sd1 <<< rs) - 64'sd1;
      rem = hi & mask;
      q = (hi - rem) / (64'sd1 <<< rs);
      thr = (mask >>> 1) + ((hi < 0) ? 64'sd1 : 64'sd0);
      return q + ((rem > thr) ? 64'sd1 : 64'sd0);
   endfunction

   function automatic void fold_sample(input logic [7:0] value);
      int       cc, pc, c;
      bit       last_pixel, last_chan;
      longint   bias, acc;
      mean_word w;
      cc = cfg.channel_count;
      if (cc == 0) cc = 1;
      if (cc > CHANNELS) cc = CHANNELS;
      pc = cfg.pixel_count;
      if (pc == 0) pc = 1;
      c = chan_pos;
      if (c >= CHANNELS) c = CHANNELS - 1;
      last_pixel = int'(pix_pos) >= pc - 1;
      last_chan = c + 1 >= cc;
      // first pixel replaces the sum
      if (pix_pos == 0) sums[c] = value;
      else sums[c] = sums[c] + value;
      if (last_pixel) begin
         bias = longint'(cfg.output_zero_point)
              - scale_q31(cfg.input_zero_point, cfg.zero_multiplier, cfg.zero_shift);
         acc = scale_q31(sums[c], cfg.sum_mult, cfg.sum_shift) + bias;
         if (acc < 0) acc = 0;
         if (acc > 255) acc = 255;
         w.mean_value = acc[7:0];
         w.channel_index = c[7:0];
         w.last_channel = last_chan;
         pending_means.push_back(w);
      end
      if (last_chan) begin
         chan_pos = 0;
         pix_pos = last_pixel ? 16'd0 : pix_pos + 16'd1;
      end else begin
         chan_pos = c + 1;
      end
   endfunction

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("error: %s", msg);
   endfunction

   function automatic logic [7:0] random_sample();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 8'd0;
      if (r < 20) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   // sender: leaves tvalid high after a handshake so back-to-back words need no re-raise
   task automatic send_sample(input logic [7:0] value);
      while (!no_idle && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fold_sample(value);
      sample_count++;
   endtask

   // drain all means, then give the pipeline time to empty of no-result words
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_MEAN_MULT:  cfg.sum_mult = data[30:0];
         REG_MEAN_SHIFT: cfg.sum_shift = data[5:0];
         REG_ZERO_MULT:  cfg.zero_multiplier = data[30:0];
         REG_ZERO_SHIFT: cfg.zero_shift = data[5:0];
         REG_IN_ZP:      cfg.input_zero_point = data[7:0];
         REG_OUT_ZP:     cfg.output_zero_point = data[7:0];
         REG_CHAN_COUNT: cfg.channel_count = data[8:0];
         REG_PIX_COUNT:  cfg.pixel_count = data[15:0];
      endcase
      write_count++;
   endtask

   // offset path must settle after a write before samples may follow
   task automatic close_config();
      csr_valid <= 1'b0;
      repeat (SETTLE) @(posedge clock);
      setting_count++;
   endtask

   task automatic apply_setting(input logic [31:0] mm, ms, zm, zs, izp, ozp, cc, pc);
      quiesce();
      write_reg(REG_MEAN_MULT, mm);
      write_reg(REG_MEAN_SHIFT, ms);
      write_reg(REG_ZERO_MULT, zm);
      write_reg(REG_ZERO_SHIFT, zs);
      write_reg(REG_IN_ZP, izp);
      write_reg(REG_OUT_ZP, ozp);
      write_reg(REG_CHAN_COUNT, cc);
      write_reg(REG_PIX_COUNT, pc);
      close_config();
   endtask

   // plausible scales divide the sum by about the pixel count; wild ones hit clamps and odd shifts
   task automatic apply_random_scales(input int cc, input int pc, input bit wild);
      int          k;
      logic [31:0] mm, ms, zm, zs;
      if (wild) begin
         mm = $urandom();
         ms = $urandom();
         zm = $urandom();
         zs = $urandom();
      end else begin
         k = $clog2(pc) + int'($urandom_range(2)) - 1;
         if (k < 0) k = 0;
         mm = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
         ms = -k;
         zm = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
         zs = -int'($urandom_range(3));
      end
      apply_setting(mm, ms, zm, zs, $urandom(), $urandom(), cc, pc);
   endtask

   task automatic test_directed();
      // reset values: half-scale multipliers, one channel, one pixel
      send_sample(8'd0);
      send_sample(8'd255);
      send_sample(8'd1);
      // zero counts behave as one
      apply_setting(32'h4000_0000, 0, 32'h4000_0000, 0, 0, 0, 0, 0);
      send_sample(8'd200);
      send_sample(8'd7);
      // right shift code -32, zero point shifted left until it wraps
      apply_setting(32'h7FFF_FFFF, 32'h20, 32'h7FFF_FFFF, 32'h1F, 255, 255, 2, 2);
      send_sample(8'd255);
      send_sample(8'd0);
      send_sample(8'd255);
      send_sample(8'd255);
      // big left shift on the sum, top of the clamp
      apply_setting(32'h7FFF_FFFF, 30, 32'h4000_0000, 0, 0, 255, 1, 1);
      send_sample(8'd255);
      send_sample(8'd1);
      send_sample(8'd128);
      // offset far below zero
      apply_setting(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 255, 0, 1, 1);
      send_sample(8'd0);
      send_sample(8'd255);
      // counts shrink in the middle of an image, positions carry over
      apply_setting(32'h4000_0000, -1, 32'h4000_0000, 0, 17, 40, 3, 4);
      repeat (5) send_sample(random_sample());
      quiesce();
      write_reg(REG_CHAN_COUNT, 1);
      close_config();
      send_sample(random_sample());
      quiesce();
      write_reg(REG_PIX_COUNT, 2);
      close_config();
      send_sample(random_sample());
   endtask

   task automatic test_wide_pixel();
      apply_random_scales(256, 1, 1'b0);
      repeat (256) send_sample(random_sample());
      // above the channel limit acts as the limit
      apply_random_scales(511, 1, 1'b1);
      repeat (256) send_sample(random_sample());
   endtask

   task automatic test_long_image();
      apply_random_scales(1, 320, 1'b0);
      repeat (320) send_sample(8'($urandom_range(255)));
   endtask

   task automatic test_backpressure();
      apply_setting(32'h4000_0000, 0, 32'h4000_0000, 0, 0, 0, 1, 1);
      no_idle = 1'b1;
      hold_left = 150;
      repeat (80) send_sample(random_sample());
      no_idle = 1'b0;
   endtask

   task automatic test_random_phases();
      int target, phase, r, cc, pc, ccx, pcx, images;
      target = sample_count + 1000;
      phase = 0;
      while (sample_count < target) begin
         r = $urandom_range(99);
         if (r < 8) cc = 0;
         else if (r < 12) cc = $urandom_range(511, 257);
         else if (r < 15) cc = 256;
         else cc = $urandom_range(8, 1);
         r = $urandom_range(99);
         if (cc > 8) pc = $urandom_range(2);
         else if (r < 8) pc = 0;
         else if (r < 20) pc = $urandom_range(64, 9);
         else pc = $urandom_range(8, 1);
         if (pc > 8 && cc > 2) cc = $urandom_range(2, 1);
         // one long stretch with no idling on either side
         if (phase == 2) begin
            cc = 4;
            pc = 8;
         end
         ccx = (cc == 0) ? 1 : (cc > CHANNELS) ? CHANNELS : cc;
         pcx = (pc == 0) ? 1 : pc;
         apply_random_scales(cc, pc, $urandom_range(3) == 0);
         no_idle = (phase == 2);
         images = (phase == 2) ? 3 : $urandom_range(3, 1);
         if (ccx * pcx > 100) images = 1;
         repeat (images * ccx * pcx) send_sample(random_sample());
         // broken image: the next setting lands mid-image
         if ($urandom_range(4) == 0) repeat ($urandom_range(ccx * pcx)) send_sample(random_sample());
         no_idle = 1'b0;
         phase++;
      end
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 30);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && !req_tready) input_stall_cycles++;
   end

   always @(posedge clock) begin : check_means
      mean_word want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         means_seen++;
         if (pending_means.size() == 0) begin
            report_error($sformatf("unexpected mean word: mean %0d channel %0d last %0b",
                                   rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast));
         end else begin
            want = pending_means.pop_front();
            if (rsp_tdata[7:0] !== want.mean_value || rsp_tdata[15:8] !== want.channel_index
                || rsp_tlast !== want.last_channel) begin
               report_error($sformatf({"mean word %0d: expected mean %0d channel %0d last %0b,",
                                       " got mean %0d channel %0d last %0b"},
                                      means_seen, want.mean_value, want.channel_index,
                                      want.last_channel, rsp_tdata[7:0], rsp_tdata[15:8],
                                      rsp_tlast));
            end
         end
      end
   end

   initial begin
      cfg = '0;
      cfg.sum_mult = 31'h4000_0000;
      cfg.zero_multiplier = 31'h4000_0000;
      cfg.channel_count = 9'd1;
      cfg.pixel_count = 16'd1;
      foreach (sums[i]) sums[i] = '0;
      chan_pos = 0;
      pix_pos = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_wide_pixel();
      test_long_image();
      test_backpressure();
      test_random_phases();

      req_tvalid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("%0d samples under %0d settings (%0d register writes), %0d channel means checked",
               sample_count, setting_count, write_count, means_seen);
      $display("input held off %0d cycles by output stalls, %0d errors",
               input_stall_cycles, error_count);
      if (error_count == 0 && pending_means.size() == 0) begin
         $display("spatial_mean_uint8_requant_core: match");
      end else begin
         $display("spatial_mean_uint8_requant_core: mismatch");
      end
      $finish;
   end

endmodule
